[design/lpam_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpam_pkg
// Shared types, constants and the home-slot hash for the linear probe
// address map.
// ----------------------------------------------------------------------------
package lpam_pkg;

    // Field widths
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int PROBE_W = 13;
    localparam int SLOT_W  = 12;
    localparam int STAT_W  = 3;
    localparam int HASH_W  = 30;

    // Table geometry
    localparam int TABLE_SIZE_DEF = 4096;
    localparam int TABLE_SIZE_MAX = (1 << 18);

    // Register file
    localparam int                APB_ADDR_W      = 3;
    localparam int                APB_DATA_W      = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_PROBES = 3'd0;
    localparam logic [PROBE_W-1:0]    PROBE_RESET     = 13'd256;

    // Commands
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_HIT         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_MISS        = 3'd1;
    localparam logic [STAT_W-1:0] STAT_INSERTED    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_OVERWRITTEN = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL        = 3'd4;
    localparam logic [STAT_W-1:0] STAT_ZERO_KEY    = 3'd5;

    // Sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE
    } lpam_state_t;

    // Fold the key into a slot hash; callers keep the low address bits
    function automatic logic [HASH_W-1:0] home_hash(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        h = (k >> 2) ^ (k >> 14) ^ (k >> 22);
        return h[HASH_W-1:0];
    endfunction

endpackage

[design/linear_probe_address_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_address_map
// Open-addressing map from 32-bit code addresses to 32-bit handles with
// linear probing over a key memory and a value memory.
// ----------------------------------------------------------------------------
//  port group | dir | contents
//  -----------+-----+---------------------------------------------------------
//  s_*        | in  | tuser: command; tdata: key, value
//  m_*        | out | tuser: found, status; tdata: result_value, slot
//  p*         | in  | APB register port, max_probes at byte address 0
//
//  An item probes from its home slot, one slot per cycle, until it ends on a
//  match, an empty slot, the probe limit or a full table; the key memory's
//  registered read sets that pace.
//  Zero-key items and lookups with a probe limit of zero end in their first
//  probe state without checking a slot.
//  After reset a clearing pass writes zero to every key slot while s_tready
//  stays low; register writes are taken meanwhile.
//  A finished item waits in its last probe cycle while m_tdata is stalled.
// ----------------------------------------------------------------------------
module linear_probe_address_map #(
    parameter int TABLE_SIZE = lpam_pkg::TABLE_SIZE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,  // key[31:0], value[63:32]
    input  logic [0:0]                          s_tuser,  // command[0]
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,  // result_value[31:0],
                                                          // slot[43:32], zero[47:44]
    output logic [3:0]                          m_tuser,  // found[0], status[3:1]
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpam_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lpam_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lpam_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import lpam_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = AW + 1;
    localparam int MW = (CW > PROBE_W) ? CW : PROBE_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);
    localparam logic [CW-1:0] SIZE_CNT  = CW'(TABLE_SIZE);

    // Memories
    logic [KEY_W-1:0] key_mem [TABLE_SIZE];
    logic [VAL_W-1:0] val_mem [TABLE_SIZE];

    // Control and payload registers
    lpam_state_t          state_reg, state_next;
    logic [AW-1:0]        clr_reg;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        limit_reg, limit_next;
    logic                 cmd_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [PROBE_W-1:0]   max_probes_reg;

    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic [VAL_W-1:0]     out_value_reg;
    logic [STAT_W-1:0]    out_status_reg;
    logic [SLOT_W-1:0]    out_slot_reg;

    // Memory ports
    logic [AW-1:0]        rd_addr;
    logic [KEY_W-1:0]     key_rdata;
    logic [VAL_W-1:0]     val_rdata;
    logic                 key_we, val_we;
    logic                 want_kw, want_vw;
    logic [AW-1:0]        wr_addr;
    logic [KEY_W-1:0]     wr_key;

    // Sequencer outputs
    logic                 s_fire, out_free, done, commit;
    logic                 res_found;
    logic [VAL_W-1:0]     res_value;
    logic [STAT_W-1:0]    res_status;
    logic                 res_has_slot;
    logic                 cfg_we;

    logic [KEY_W-1:0]     in_key;
    logic [VAL_W-1:0]     in_val;
    logic [HASH_W-1:0]    in_hash;
    logic [MW-1:0]        probe_ext, size_ext, lim_clamp;
    logic [SLOT_W+AW-1:0] slot_ext;

    assign in_key   = s_tdata[KEY_W-1:0];
    assign in_val   = s_tdata[KEY_W+VAL_W-1:KEY_W];
    assign in_hash  = home_hash(in_key);
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign commit   = done && out_free;

    // Clamp the lookup probe limit to the table size
    assign probe_ext = MW'(max_probes_reg);
    assign size_ext  = MW'(TABLE_SIZE);
    assign lim_clamp = (probe_ext > size_ext) ? size_ext : probe_ext;

    // Low slot bits, zero-padded for small tables
    assign slot_ext = {{SLOT_W{1'b0}}, idx_reg};

    // Register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr == ADDR_MAX_PROBES);
    assign prdata = (paddr == ADDR_MAX_PROBES) ? APB_DATA_W'(max_probes_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_probes_reg <= PROBE_RESET;
        end else if (cfg_we) begin
            max_probes_reg <= pwdata[PROBE_W-1:0];
        end
    end

    // Next state, memory addresses and result selection
    always_comb begin
        state_next   = state_reg;
        rd_addr      = idx_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        limit_next   = limit_reg;
        want_kw      = 1'b0;
        want_vw      = 1'b0;
        wr_addr      = idx_reg;
        wr_key       = key_reg;
        done         = 1'b0;
        res_found    = 1'b0;
        res_value    = '0;
        res_status   = STAT_MISS;
        res_has_slot = 1'b0;
        key_we       = 1'b0;
        val_we       = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                key_we  = 1'b1;
                wr_addr = clr_reg;
                wr_key  = '0;
                if (clr_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_addr  = in_hash[AW-1:0];
                idx_next = in_hash[AW-1:0];
                n_next   = '0;
                limit_next = (s_tuser[0] == CMD_INSERT) ? SIZE_CNT : lim_clamp[CW-1:0];
                if (s_fire) begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (key_reg == '0) begin
                    done       = 1'b1;
                    res_status = (cmd_reg == CMD_INSERT) ? STAT_ZERO_KEY : STAT_MISS;
                end else if (n_reg == limit_reg) begin
                    done       = 1'b1;
                    res_status = (cmd_reg == CMD_INSERT) ? STAT_FULL : STAT_MISS;
                end else if (key_rdata == key_reg) begin
                    done         = 1'b1;
                    res_has_slot = 1'b1;
                    if (cmd_reg == CMD_INSERT) begin
                        res_status = STAT_OVERWRITTEN;
                        want_vw    = 1'b1;
                    end else begin
                        res_status = STAT_HIT;
                        res_found  = 1'b1;
                        res_value  = val_rdata;
                    end
                end else if (key_rdata == '0) begin
                    done = 1'b1;
                    if (cmd_reg == CMD_INSERT) begin
                        res_status   = STAT_INSERTED;
                        res_has_slot = 1'b1;
                        want_kw      = 1'b1;
                        want_vw      = 1'b1;
                    end
                end else begin
                    // Advance to the next slot, wrapping at the end
                    idx_next = idx_reg + 1'b1;
                    n_next   = n_reg + 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
                // Hold the memory writes until the result register has room
                key_we = want_kw && out_free;
                val_we = want_vw && out_free;
                if (commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // Item registers
    always_ff @(posedge aclk) begin
        if (s_fire || state_reg == S_PROBE) begin
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            limit_reg <= limit_next;
        end
        if (s_fire) begin
            cmd_reg <= s_tuser[0];
            key_reg <= in_key;
            val_reg <= in_val;
        end
    end

    // Key and value memories, registered read
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= wr_key;
        end
        key_rdata <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[idx_reg] <= val_reg;
        end
        val_rdata <= val_mem[rd_addr];
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_found_reg  <= res_found;
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
            out_slot_reg   <= res_has_slot ? slot_ext[SLOT_W-1:0] : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_slot_reg, out_value_reg};
    assign m_tuser  = {out_status_reg, out_found_reg};

    // Checks
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("input accepted during key clear");

    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE) |-> (n_reg <= limit_reg))
        else $error("probe count past limit");

    a_insert_key_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (key_we && state_reg == S_PROBE) |-> (wr_key != '0))
        else $error("zero key written as an entry");

    a_write_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (val_we && state_reg == S_PROBE) |=> m_tvalid)
        else $error("entry written without a result");

    a_found_is_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_found_reg) |-> (out_status_reg == STAT_HIT))
        else $error("found flag without hit status");

endmodule
